FILE: sv/iechk_pkg.sv
// Shared types and constants for the ICMP echo reply checker.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package iechk_pkg;

    // received map geometry: DUP_BITS bits held as rows of MAP_WORD bits
    localparam int DUP_BITS        = 1024;
    localparam int MAP_WORD        = 32;
    localparam int MAP_ROWS        = DUP_BITS / MAP_WORD;
    localparam int MAP_IDX_W       = $clog2(DUP_BITS);
    localparam int MAP_BIT_W       = $clog2(MAP_WORD);
    localparam int MAP_ROW_W       = MAP_IDX_W - MAP_BIT_W;

    localparam int TIMESTAMP_BYTES = 8;
    localparam int ICMP_HDR_BYTES  = 8;

    // result queue
    localparam int RES_Q_DEPTH     = 4;
    localparam int RES_Q_PTR_W     = $clog2(RES_Q_DEPTH);
    localparam int RES_Q_CNT_W     = RES_Q_PTR_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENT       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN = 8'd1;
    localparam logic [10:0]          PAYLOAD_LEN_RST = 11'd56;

    // ICMP byte offsets after the IP header
    localparam logic [15:0] OFF_TYPE    = 16'd0;
    localparam logic [15:0] OFF_CODE    = 16'd1;
    localparam logic [15:0] OFF_ID_LO   = 16'd4;
    localparam logic [15:0] OFF_ID_HI   = 16'd5;
    localparam logic [15:0] OFF_SEQ_LO  = 16'd6;
    localparam logic [15:0] OFF_SEQ_HI  = 16'd7;

    localparam logic [7:0]  ECHO_REPLY_TYPE = 8'd0;

    typedef enum logic [1:0] {
        VERDICT_OK      = 2'd0,
        VERDICT_FAIL    = 2'd1,
        VERDICT_FOREIGN = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        MAP_NONE,
        MAP_CLEAR,
        MAP_TEST
    } map_op_t;

    typedef struct packed {
        verdict_t    verdict;
        logic        duplicate;
        logic [15:0] seq_seen;
    } result_t;

endpackage

FILE: sv/iechk_ifs.sv
// Valid/ready channel interfaces: packet input, result output, configuration writes.
// Depends on iechk_pkg.
`timescale 1ns / 1ps

interface iechk_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  data_byte;
    logic        last;
    logic [15:0] seq_sent;

    modport source (output valid, cmd, data_byte, last, seq_sent, input ready);
    modport sink   (input valid, cmd, data_byte, last, seq_sent, output ready);
endinterface

interface iechk_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic        duplicate;
    logic [15:0] seq_seen;

    modport source (output valid, verdict, duplicate, seq_seen, input ready);
    modport sink   (input valid, verdict, duplicate, seq_seen, output ready);
endinterface

interface iechk_cfg_if import iechk_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/iechk_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module iechk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/icmp_echo_reply_checker.sv
// ICMP echo reply checker: one packet byte or send request per cycle.
// res.valid rises once the final byte's result is registered in stage 1 and then in the result queue.
// Throughput: one beat per cycle through the map RAM read-modify-write (read at accept,
// write in stage 1, one-deep forwarding); input stalls on a full queue counting stage 1.
// Reset: packet state clears and config takes its reset values at once; the received map
// reads as zero through per-row valid flops, so no clearing pass is needed.
`timescale 1ns / 1ps

module icmp_echo_reply_checker
    import iechk_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    iechk_cfg_if.sink     cfg,
    iechk_in_if.sink      pkt,
    iechk_out_if.source   res
);

    // ---------------- configuration ----------------
    logic [15:0] ident_reg;
    logic [10:0] payload_len_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg       <= '0;
            payload_len_reg <= PAYLOAD_LEN_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_IDENT)
            begin
                ident_reg <= cfg.data;
            end
            else if (cfg.index == CFG_PAYLOAD_LEN)
            begin
                payload_len_reg <= cfg.data[10:0];
            end
        end
    end

    // ---------------- packet parse (stage 0) ----------------
    logic [15:0] byte_position_reg;
    logic [5:0]  header_bytes_reg;
    logic [7:0]  reply_type_reg;
    logic [7:0]  reply_code_reg;
    logic [15:0] reply_id_reg;
    logic [15:0] reply_seq_reg;
    logic        pattern_bad_reg;

    logic [5:0]  header_bytes_next;
    logic [7:0]  reply_type_next;
    logic [7:0]  reply_code_next;
    logic [15:0] reply_id_next;
    logic [15:0] reply_seq_next;
    logic        pattern_bad_next;

    logic [15:0] off;
    logic [15:0] data_k;
    logic        in_icmp;
    logic        pkt_fire;

    logic [16:0] pkt_len;
    logic        too_short;
    logic        hdr_cut;
    logic        not_reply;
    logic        wrong_id;
    logic        data_cut;

    map_op_t              s0_op;
    verdict_t             s0_verdict;
    logic [MAP_IDX_W-1:0] s0_idx;

    always_comb
    begin
        header_bytes_next = header_bytes_reg;
        reply_type_next   = reply_type_reg;
        reply_code_next   = reply_code_reg;
        reply_id_next     = reply_id_reg;
        reply_seq_next    = reply_seq_reg;
        pattern_bad_next  = pattern_bad_reg;

        if (byte_position_reg == 16'd0)
        begin
            header_bytes_next = {pkt.data_byte[3:0], 2'b00};
        end
        in_icmp = byte_position_reg >= {10'd0, header_bytes_next};
        off     = byte_position_reg - {10'd0, header_bytes_next};
        data_k  = off - 16'(ICMP_HDR_BYTES);

        if (in_icmp)
        begin
            case (off)
                OFF_TYPE:   reply_type_next = pkt.data_byte;
                OFF_CODE:   reply_code_next = pkt.data_byte;
                OFF_ID_LO:  reply_id_next   = {reply_id_reg[15:8], pkt.data_byte};
                OFF_ID_HI:  reply_id_next   = {pkt.data_byte, reply_id_reg[7:0]};
                OFF_SEQ_LO: reply_seq_next  = {reply_seq_reg[15:8], pkt.data_byte};
                OFF_SEQ_HI: reply_seq_next  = {pkt.data_byte, reply_seq_reg[7:0]};
                default:
                begin
                    if (off >= 16'(ICMP_HDR_BYTES) && data_k >= 16'(TIMESTAMP_BYTES) &&
                        data_k < {5'd0, payload_len_reg} && pkt.data_byte != data_k[7:0])
                    begin
                        pattern_bad_next = 1'b1;
                    end
                end
            endcase
        end

        // verdict as of this byte, in case it is the final one
        pkt_len   = {1'b0, byte_position_reg} + 17'd1;
        too_short = pkt_len < 17'({1'b0, payload_len_reg} + 12'(ICMP_HDR_BYTES));
        hdr_cut   = pkt_len < 17'({1'b0, header_bytes_next} + 7'(ICMP_HDR_BYTES));
        not_reply = reply_type_next != ECHO_REPLY_TYPE || reply_code_next != 8'd0;
        wrong_id  = reply_id_next != ident_reg;
        data_cut  = pkt_len < 17'({6'd0, header_bytes_next} + 12'(ICMP_HDR_BYTES)
                                  + {1'b0, payload_len_reg});

        s0_op      = MAP_NONE;
        s0_verdict = VERDICT_OK;
        if (too_short)
        begin
            s0_verdict = VERDICT_FOREIGN;
        end
        else if (hdr_cut || not_reply)
        begin
            s0_verdict = VERDICT_FAIL;
        end
        else if (wrong_id)
        begin
            s0_verdict = VERDICT_FOREIGN;
        end
        else
        begin
            s0_op = MAP_TEST;
            // map bit decides duplicate only; fail is known now
            s0_verdict = (data_cut || pattern_bad_next) ? VERDICT_FAIL : VERDICT_OK;
        end

        if (pkt.cmd)
        begin
            s0_op = MAP_CLEAR;
        end
        else if (!pkt.last)
        begin
            s0_op = MAP_NONE;
        end

        s0_idx = pkt.cmd ? pkt.seq_sent[MAP_IDX_W-1:0] : reply_seq_next[MAP_IDX_W-1:0];
    end

    assign pkt_fire = pkt.valid && pkt.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            header_bytes_reg  <= '0;
            reply_type_reg    <= '0;
            reply_code_reg    <= '0;
            reply_id_reg      <= '0;
            reply_seq_reg     <= '0;
            pattern_bad_reg   <= 1'b0;
        end
        else if (pkt_fire && !pkt.cmd)
        begin
            if (pkt.last)
            begin
                byte_position_reg <= '0;
                header_bytes_reg  <= '0;
                reply_type_reg    <= '0;
                reply_code_reg    <= '0;
                reply_id_reg      <= '0;
                reply_seq_reg     <= '0;
                pattern_bad_reg   <= 1'b0;
            end
            else
            begin
                if (byte_position_reg != 16'hFFFF)
                begin
                    byte_position_reg <= byte_position_reg + 16'd1;
                end
                header_bytes_reg <= header_bytes_next;
                reply_type_reg   <= reply_type_next;
                reply_code_reg   <= reply_code_next;
                reply_id_reg     <= reply_id_next;
                reply_seq_reg    <= reply_seq_next;
                pattern_bad_reg  <= pattern_bad_next;
            end
        end
    end

    // ---------------- stage 1: map read-modify-write ----------------
    logic                 s1_valid_reg;
    logic                 s1_res_reg;
    map_op_t              s1_op_reg;
    verdict_t             s1_verdict_reg;
    logic [15:0]          s1_seq_reg;
    logic [MAP_ROW_W-1:0] s1_row_reg;
    logic [MAP_BIT_W-1:0] s1_bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_res_reg   <= 1'b0;
            s1_op_reg    <= MAP_NONE;
        end
        else
        begin
            s1_valid_reg <= pkt_fire;
            s1_res_reg   <= pkt_fire && !pkt.cmd && pkt.last;
            s1_op_reg    <= pkt_fire ? s0_op : MAP_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_verdict_reg <= s0_verdict;
        s1_seq_reg     <= reply_seq_next;
        s1_row_reg     <= s0_idx[MAP_IDX_W-1:MAP_BIT_W];
        s1_bit_reg     <= s0_idx[MAP_BIT_W-1:0];
    end

    logic [MAP_WORD-1:0]  ram_rdata;
    logic [MAP_WORD-1:0]  cur_row;
    logic [MAP_WORD-1:0]  new_row;
    logic                 map_we;
    logic                 dup_bit;
    logic [MAP_ROWS-1:0]  row_vld_reg;

    // previous cycle's write, for a back-to-back access to the same row
    logic                 last_we_reg;
    logic [MAP_ROW_W-1:0] last_row_reg;
    logic [MAP_WORD-1:0]  last_wdata_reg;

    iechk_ram #(
        .WIDTH (MAP_WORD),
        .DEPTH (MAP_ROWS)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (s1_row_reg),
        .wdata (new_row),
        .raddr (s0_idx[MAP_IDX_W-1:MAP_BIT_W]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (last_we_reg && last_row_reg == s1_row_reg)
        begin
            cur_row = last_wdata_reg;
        end
        else if (row_vld_reg[s1_row_reg])
        begin
            cur_row = ram_rdata;
        end
        else
        begin
            cur_row = '0;
        end
        dup_bit = cur_row[s1_bit_reg];
        new_row = cur_row;
        new_row[s1_bit_reg] = (s1_op_reg == MAP_TEST);
        map_we  = s1_valid_reg && (s1_op_reg != MAP_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            last_we_reg <= 1'b0;
        end
        else
        begin
            last_we_reg <= map_we;
            if (map_we)
            begin
                row_vld_reg[s1_row_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_row_reg   <= s1_row_reg;
        last_wdata_reg <= new_row;
    end

    // ---------------- result queue ----------------
    result_t                q_mem_reg [RES_Q_DEPTH];
    logic [RES_Q_PTR_W-1:0] q_wr_reg;
    logic [RES_Q_PTR_W-1:0] q_rd_reg;
    logic [RES_Q_CNT_W-1:0] q_cnt_reg;
    logic [RES_Q_CNT_W-1:0] q_cnt_next;
    logic                   q_push;
    logic                   q_pop;
    result_t                s1_result;

    always_comb
    begin
        s1_result.verdict   = s1_verdict_reg;
        s1_result.duplicate = (s1_op_reg == MAP_TEST) ? dup_bit : 1'b0;
        s1_result.seq_seen  = s1_seq_reg;
    end

    assign q_push = s1_valid_reg && s1_res_reg;
    assign q_pop  = res.valid && res.ready;
    assign q_cnt_next = q_cnt_reg + {{RES_Q_PTR_W{1'b0}}, q_push}
                                  - {{RES_Q_PTR_W{1'b0}}, q_pop};

    // queue plus the beat in stage 1 must leave room for one more
    assign pkt.ready = ({1'b0, q_cnt_reg} + {{RES_Q_CNT_W{1'b0}}, q_push})
                       < {1'b0, RES_Q_CNT_W'(RES_Q_DEPTH)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            if (q_push)
            begin
                q_wr_reg <= q_wr_reg + RES_Q_PTR_W'(1);
            end
            if (q_pop)
            begin
                q_rd_reg <= q_rd_reg + RES_Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem_reg[q_wr_reg] <= s1_result;
        end
    end

    assign res.valid     = q_cnt_reg != '0;
    assign res.verdict   = q_mem_reg[q_rd_reg].verdict;
    assign res.duplicate = q_mem_reg[q_rd_reg].duplicate;
    assign res.seq_seen  = q_mem_reg[q_rd_reg].seq_seen;

endmodule
